### hdl/pcn_pkg.sv
// Package for the point cloud unit-sphere normalizer.
// Holds sizes, status codes and sequencer states; no dependencies.
package pcn_pkg;
  localparam int MaxPoints = 1024;
  localparam int IdxW      = 10;
  localparam int CntW      = 11;
  localparam int CoordW    = 16;
  localparam int SumW      = 26;
  localparam int RadW      = 17;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_RAD = 2'd1,
    ST_INVALID  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_WALK_RD, S_WALK_SQ, S_SQRT, S_WALK_NEXT,
    S_RD_MEM, S_NDIV, S_OUT
  } state_t;
endpackage

### hdl/pcn_divider.sv
// Restoring signed divider, one quotient bit per cycle, truncates toward zero.
// Depends on pcn_pkg for nothing but house style.
module pcn_divider import pcn_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [47:0] dividend,
  input  logic        [31:0] divisor,
  output logic               done,
  output logic signed [47:0] quotient
);
  logic [47:0] num;
  logic [31:0] den;
  logic [32:0] rem;
  logic [5:0]  cnt;
  logic        neg;
  logic        busy;
  logic [32:0] trial;

  assign trial = {rem[31:0], num[47]} - {1'b0, den};

  // Shift one bit of the magnitude into the remainder each cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd48;
        neg  <= dividend[47];
        num  <= dividend[47] ? 48'(-dividend) : dividend;
        den  <= divisor;
        rem  <= '0;
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial;
          num <= {num[46:0], 1'b1};
        end else begin
          rem <= {rem[31:0], num[47]};
          num <= {num[46:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg ? -$signed(num) : $signed(num);
endmodule

### hdl/point_cloud_unit_sphere_normalizer.sv
// Top level of the point cloud unit-sphere normalizer.
// Depends on pcn_pkg and pcn_divider.
//
// channel | dir | tdata fields (low bit up)                    | tuser
// s_axis  | in  | coord_x, coord_y, coord_z, point_index (pad 6)| op; tlast = is_final
// m_axis  | out | norm_x, norm_y, norm_z, radius (pad 7)        | status
//
// A plain load raises its result valid from the S_OUT state, and the next item
// is taken only after that result is sent. A completing load runs three
// divisions for the centroid, then per stored point three squares and an
// 18-step root. A read runs three passes through the shared divider.
// Reset is synchronous; tready is low while an item is at work or unsent.
module point_cloud_unit_sphere_normalizer import pcn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // coord_x, coord_y, coord_z, point_index
  input  logic        s_axis_tlast,
  input  logic        s_axis_tuser,  // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // norm_x, norm_y, norm_z, radius
  output logic [1:0]  m_axis_tuser   // status
);
  state_t state, state_next;

  logic [47:0]            mem [MaxPoints];
  logic [47:0]            rd_data;
  logic [IdxW-1:0]        rd_addr;
  logic [CntW-1:0]        point_count;
  logic signed [SumW-1:0] sum [3];
  logic signed [CoordW:0] cen [3];
  logic [RadW-1:0]        max_radius;
  logic                   overflow_seen, set_complete;
  logic [CntW-1:0]        walk;
  logic [1:0]             axis;
  logic [IdxW-1:0]        ridx;
  logic [35:0]            sq_acc;
  logic [35:0]            sq_v;
  logic [17:0]            root;
  logic [4:0]             rcnt;
  logic signed [15:0]     nres [3];
  logic [1:0]             out_status;
  logic [RadW-1:0]        out_radius;
  logic                   accept, out_fire;
  logic signed [CoordW:0] diff;
  logic [CoordW:0]        dmag;
  logic                   div_start, div_done, div_wait;
  logic signed [47:0]     div_num, div_q;
  logic [31:0]            div_den;
  logic [47:0]            in_pt;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid;
  assign in_pt = s_axis_tdata[47:0];

  pcn_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_num),
    .divisor(div_den), .done(div_done), .quotient(div_q)
  );

  // Centered value of the current axis from the registered store word
  always_comb begin
    diff = $signed({rd_data[axis*16+15], rd_data[axis*16 +: 16]}) - cen[axis];
    dmag = diff[CoordW] ? (CoordW+1)'(0) - diff : diff;
  end

  // Shared divider operands: centroid or normalization
  always_comb begin
    if (state == S_DIV) begin
      div_num = 48'(sum[axis]);
      div_den = 32'(point_count);
    end else begin
      div_num = 48'(diff) <<< 15;
      div_den = 32'(max_radius);
    end
  end
  assign div_start = (state == S_DIV || state == S_NDIV) && !div_wait && !div_done;

  // Memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (accept && !s_axis_tuser && !(set_complete ? 1'b0 : point_count[CntW-1]))
      mem[set_complete ? '0 : point_count[IdxW-1:0]] <= in_pt;
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept) state_next = s_axis_tuser ? S_RD_MEM :
                                      (s_axis_tlast ? S_DIV : S_OUT);
      S_DIV:  if (div_done && axis == 2'd2) state_next = S_WALK_RD;
      S_WALK_RD: state_next = (walk == point_count) ? S_OUT : S_WALK_SQ;
      S_WALK_SQ: if (axis == 2'd2) state_next = S_SQRT;
      S_SQRT: if (rcnt == 5'd17) state_next = S_WALK_NEXT;
      S_WALK_NEXT: state_next = S_WALK_RD;
      S_RD_MEM: state_next = S_NDIV;
      S_NDIV: if (div_done && axis == 2'd2) state_next = S_OUT;
      S_OUT:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign rd_addr = (state == S_IDLE || state == S_RD_MEM || state == S_NDIV) ? ridx
                   : walk[IdxW-1:0];

  // Sequencer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      point_count <= '0;
      overflow_seen <= 1'b0;
      set_complete <= 1'b0;
      max_radius <= '0;
      m_axis_tvalid <= 1'b0;
      walk <= '0;
      rcnt <= '0;
      axis <= '0;
      div_wait <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        sum[i] <= '0;
        cen[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (out_fire) m_axis_tvalid <= 1'b0;
      // Track one division in flight
      if (div_start) div_wait <= 1'b1;
      else if (div_done) div_wait <= 1'b0;
      case (state)
        S_IDLE: if (accept) begin
          ridx <= s_axis_tdata[57:48];
          axis <= '0;
          walk <= '0;
          rcnt <= '0;
          out_radius <= '0;
          for (int i = 0; i < 3; i++) nres[i] <= '0;
          if (!s_axis_tuser) begin
            logic [CntW-1:0] pc;
            pc = set_complete ? '0 : point_count;
            if (set_complete) begin
              overflow_seen <= 1'b0;
              set_complete <= 1'b0;
              max_radius <= '0;
            end
            if (pc[CntW-1]) begin
              overflow_seen <= 1'b1;
              point_count <= pc;
              out_status <= ST_OVERFLOW;
            end else begin
              point_count <= pc + CntW'(1);
              out_status <= ST_OK;
              for (int i = 0; i < 3; i++)
                sum[i] <= (set_complete ? SumW'(0) : sum[i])
                          + SumW'($signed(in_pt[i*16 +: 16]));
            end
          end else begin
            out_status <= ST_OK;
          end
        end
        S_DIV: if (div_done) begin
          cen[axis] <= (point_count == '0) ? '0 : (CoordW+1)'(div_q);
          axis <= (axis == 2'd2) ? 2'd0 : axis + 2'd1;
          if (axis == 2'd2) max_radius <= '0;
        end
        S_WALK_RD: begin
          axis <= '0;
          sq_acc <= '0;
          if (walk == point_count) begin
            set_complete <= 1'b1;
            out_radius <= max_radius;
            out_status <= overflow_seen ? ST_OVERFLOW :
                          (max_radius == '0 ? ST_ZERO_RAD : ST_OK);
          end
        end
        S_WALK_SQ: begin
          sq_acc <= sq_acc + 36'(dmag) * 36'(dmag);
          axis <= axis + 2'd1;
          if (axis == 2'd2) begin
            sq_v <= sq_acc + 36'(dmag) * 36'(dmag);
            root <= '0;
            rcnt <= '0;
          end
        end
        S_SQRT: begin
          logic [17:0] t;
          t = root | (18'd1 << (5'd17 - rcnt));
          if (36'(t) * 36'(t) <= sq_v) root <= t;
          rcnt <= rcnt + 5'd1;
        end
        S_WALK_NEXT: begin
          rcnt <= '0;
          if (RadW'(root) > max_radius) max_radius <= RadW'(root);
          walk <= walk + 1'b1;
        end
        S_RD_MEM: begin
          axis <= '0;
          if (!set_complete) out_status <= ST_INVALID;
          else if (CntW'(ridx) >= point_count) begin
            out_status <= ST_INVALID;
            out_radius <= max_radius;
          end else if (max_radius == '0) out_status <= ST_ZERO_RAD;
          else out_radius <= max_radius;
        end
        S_NDIV: if (div_done) begin
          if (out_status == ST_OK && set_complete)
            nres[axis] <= (div_q > 48'sd32767) ? 16'sd32767 :
                          (div_q < -48'sd32768) ? -16'sd32768 : 16'(div_q);
          axis <= (axis == 2'd2) ? 2'd0 : axis + 2'd1;
        end
        S_OUT: m_axis_tvalid <= 1'b1;
        default: ;
      endcase
    end
  end

  assign m_axis_tdata = {7'd0, out_radius, nres[2], nres[1], nres[0]};
  assign m_axis_tuser = out_status;

  // No new item while a result waits
  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("accepted with result pending");
  a_count: assert property (@(posedge clk) disable iff (rst)
    point_count <= CntW'(MaxPoints)) else $error("count over store size");
  a_ok_rad: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == ST_ZERO_RAD) |-> m_axis_tdata[47:0] == '0)
    else $error("zero radius result with data");
endmodule

### tb/pcn_checker.sv
`timescale 1ns / 1ps
// Result checker for the point cloud unit-sphere normalizer: watches both streams,
// predicts every result from the accepted items and compares field by field.
// Depends on pcn_pkg.
module pcn_checker import pcn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [71:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  output int          fails,
  output int          pending
);
  typedef struct {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic [RadW-1:0]    rad;
    status_t            st;
  } norm_result_t;

  logic signed [CoordW-1:0] pts_x [MaxPoints];
  logic signed [CoordW-1:0] pts_y [MaxPoints];
  logic signed [CoordW-1:0] pts_z [MaxPoints];
  int unsigned       n_pts;
  longint            acc_x, acc_y, acc_z;
  longint            cen_x, cen_y, cen_z;
  longint unsigned   max_rad;
  bit                ovf_seen, set_done;
  norm_result_t      norm_q [$];

  // Bitwise integer square root, floor
  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [15:0] scale_axis(longint d);
    longint q;
    q = (d * 32768) / longint'(max_rad);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  // Centroid, then the largest centered distance
  function automatic void close_set();
    longint dx, dy, dz;
    longint unsigned r;
    max_rad = 0;
    cen_x = 0; cen_y = 0; cen_z = 0;
    if (n_pts != 0) begin
      cen_x = acc_x / longint'(n_pts);
      cen_y = acc_y / longint'(n_pts);
      cen_z = acc_z / longint'(n_pts);
    end
    for (int i = 0; i < n_pts; i++) begin
      dx = longint'(pts_x[i]) - cen_x;
      dy = longint'(pts_y[i]) - cen_y;
      dz = longint'(pts_z[i]) - cen_z;
      r = int_root(dx * dx + dy * dy + dz * dz);
      if (r > max_rad) max_rad = r;
    end
    set_done = 1;
  endfunction

  function automatic logic [RadW-1:0] rad_field();
    return (max_rad > 131071) ? 17'h1FFFF : max_rad[RadW-1:0];
  endfunction

  function automatic norm_result_t predict_norm(bit rd, logic [63:0] d, bit fin);
    norm_result_t r;
    bit dropped;
    int unsigned idx;
    r = '{0, 0, 0, 0, ST_OK};
    idx = d[57:48];
    dropped = 0;
    if (!rd) begin
      if (set_done) begin
        n_pts = 0;
        acc_x = 0; acc_y = 0; acc_z = 0;
        ovf_seen = 0;
        set_done = 0;
        max_rad = 0;
      end
      if (n_pts >= MaxPoints) begin
        dropped = 1;
        ovf_seen = 1;
      end else begin
        pts_x[n_pts] = d[15:0];
        pts_y[n_pts] = d[31:16];
        pts_z[n_pts] = d[47:32];
        acc_x += longint'($signed(d[15:0]));
        acc_y += longint'($signed(d[31:16]));
        acc_z += longint'($signed(d[47:32]));
        n_pts++;
      end
      if (fin) begin
        close_set();
        r.rad = rad_field();
        if (ovf_seen) r.st = ST_OVERFLOW;
        else if (max_rad == 0) r.st = ST_ZERO_RAD;
      end else if (dropped) begin
        r.st = ST_OVERFLOW;
      end
    end else if (!set_done) begin
      r.st = ST_INVALID;
    end else if (idx >= n_pts) begin
      r.st = ST_INVALID;
      r.rad = rad_field();
    end else if (max_rad == 0) begin
      r.st = ST_ZERO_RAD;
    end else begin
      r.nx = scale_axis(longint'(pts_x[idx]) - cen_x);
      r.ny = scale_axis(longint'(pts_y[idx]) - cen_y);
      r.nz = scale_axis(longint'(pts_z[idx]) - cen_z);
      r.rad = rad_field();
    end
    return r;
  endfunction

  // Retire results first, then record the new item's expectation
  always @(posedge clk) begin
    norm_result_t w;
    if (rst) begin
      n_pts <= 0;
      acc_x <= 0; acc_y <= 0; acc_z <= 0;
      cen_x <= 0; cen_y <= 0; cen_z <= 0;
      max_rad <= 0;
      ovf_seen <= 0;
      set_done <= 0;
      fails <= 0;
      pending <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (norm_q.size() == 0) begin
          $error("result with nothing expected: tdata %h tuser %0d", m_axis_tdata,
                 m_axis_tuser);
          fails++;
        end else begin
          w = norm_q.pop_front();
          if (m_axis_tdata[15:0] !== w.nx) begin
            $error("norm_x expected %0d got %0d", w.nx, $signed(m_axis_tdata[15:0]));
            fails++;
          end
          if (m_axis_tdata[31:16] !== w.ny) begin
            $error("norm_y expected %0d got %0d", w.ny, $signed(m_axis_tdata[31:16]));
            fails++;
          end
          if (m_axis_tdata[47:32] !== w.nz) begin
            $error("norm_z expected %0d got %0d", w.nz, $signed(m_axis_tdata[47:32]));
            fails++;
          end
          if (m_axis_tdata[64:48] !== w.rad) begin
            $error("radius expected %0d got %0d", w.rad, m_axis_tdata[64:48]);
            fails++;
          end
          if (m_axis_tuser !== w.st) begin
            $error("status expected %0d got %0d", w.st, m_axis_tuser);
            fails++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        norm_q.insert(norm_q.size(),
                      predict_norm(s_axis_tuser, s_axis_tdata, s_axis_tlast));
      pending <= norm_q.size();
    end
  end
endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Testbench top for the point cloud unit-sphere normalizer: clock, reset,
// item stimulus with idling phases and the verdict. Depends on pcn_pkg, pcn_checker and the normalizer top.
module tb import pcn_pkg::*;;
  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  int          fails;
  int          pending;
  int          idle_mode;   // 0 none, 1 sender, 2 receiver, 3 both
  int          n_items;
  bit          hold_req;

  localparam bit OpLoad = 1'b0;
  localparam bit OpRead = 1'b1;

  point_cloud_unit_sphere_normalizer dut (.*);

  pcn_checker chk (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Run limit
  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    m_axis_tready <= 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_axis_tready <= 0;
        hold_req = 0;
        repeat (600) @(posedge clk);
      end
      if (idle_mode == 2) m_axis_tready <= ($urandom_range(99) >= 59);
      else if (idle_mode == 3) m_axis_tready <= ($urandom_range(99) >= 22);
      else m_axis_tready <= 1;
    end
  end

  // Offer one item and hold it until accepted
  task automatic put_item(bit rd, logic [15:0] x, logic [15:0] y, logic [15:0] z,
                          bit fin, logic [9:0] idx);
    while ((idle_mode == 1 && $urandom_range(99) < 59) ||
           (idle_mode == 3 && $urandom_range(99) < 22)) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {6'd0, idx, z, y, x};
    s_axis_tlast  <= fin;
    s_axis_tuser  <= rd;
    n_items++;
    @(negedge clk);
    while (!s_axis_tready) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic logic [15:0] rnd_coord(bit wide);
    if (wide) return 16'($urandom);
    return 16'($signed($urandom_range(4000)) - 2000);
  endfunction

  task automatic load_pt(logic [15:0] x, logic [15:0] y, logic [15:0] z, bit fin);
    put_item(OpLoad, x, y, z, fin, 10'($urandom));
  endtask

  task automatic read_pt(logic [9:0] idx);
    put_item(OpRead, 16'($urandom), 16'($urandom), 16'($urandom),
             1'($urandom_range(1)), idx);
  endtask

  initial begin
    int n, n_reads, set_no;
    bit wide;
    rst <= 1;
    s_axis_tvalid <= 0;
    s_axis_tdata <= 0;
    s_axis_tlast <= 0;
    s_axis_tuser <= 0;
    idle_mode = 0;
    n_items = 0;
    hold_req = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Read before any set, single-point set with zero radius
    read_pt(0);
    load_pt(16'h1234, 16'h8000, 16'h7FFF, 1);
    read_pt(0);
    read_pt(5);
    // Extreme coordinates
    load_pt(16'h8000, 16'h8000, 16'h8000, 0);
    read_pt(0);
    load_pt(16'h7FFF, 16'h7FFF, 16'h7FFF, 0);
    load_pt(16'h0000, 16'h0000, 16'h0000, 0);
    load_pt(16'h7FFF, 16'h8000, 16'h0000, 1);
    for (int i = 0; i < 5; i++) read_pt(10'(i));
    read_pt(10'h3FF);
    // Point exactly at the radius on an axis saturates to full scale
    load_pt(16'd0, 16'd0, 16'd0, 0);
    load_pt(16'd512, 16'd0, 16'd0, 1);
    read_pt(0);
    read_pt(1);
    read_pt(2);

    // Random sets, idling mode rotated per set
    set_no = 0;
    while (n_items < 1700) begin
      idle_mode = set_no % 4;
      wide = 1'($urandom_range(1));
      if (set_no == 6) begin
        // Fill the store, then overflow loads, the last one completing
        for (int i = 0; i < MaxPoints; i++)
          load_pt(16'($urandom), 16'($urandom), 16'($urandom), 0);
        load_pt(16'($urandom), 16'($urandom), 16'($urandom), 0);
        load_pt(16'($urandom), 16'($urandom), 16'($urandom), 0);
        load_pt(16'($urandom), 16'($urandom), 16'($urandom), 1);
        n = MaxPoints;
      end else begin
        n = $urandom_range(12, 1);
        for (int i = 0; i < n; i++) begin
          load_pt(rnd_coord(wide), rnd_coord(wide), rnd_coord(wide), i == n - 1);
          // Occasional read into an open set
          if (i < n - 1 && $urandom_range(9) == 0) read_pt(10'($urandom_range(n - 1)));
        end
      end
      if (set_no == 2) hold_req = 1;
      n_reads = $urandom_range(10, 3);
      for (int i = 0; i < n_reads; i++) begin
        if ($urandom_range(5) == 0) read_pt(10'($urandom));
        else read_pt(10'($urandom_range(n - 1)));
      end
      set_no++;
    end
    s_axis_tvalid <= 0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
